@@ src/ssav_pkg.sv @@
`default_nettype none

package ssav_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF = 20;

  localparam int STEP_BITS = 24;
  localparam int CFG_LEN_W = 20;
  localparam int ENV_W = 16;
  localparam int DUTY_W = 17;
  localparam int PEAK_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [ENV_W-1:0] ENV_ONE = 16'd32768;
  localparam logic [SAMPLE_W-1:0] SAT_LIMIT = 16'd32000;
  localparam logic [ENV_W-1:0] SUSTAIN_RST = 16'd32768;
  localparam logic [DUTY_W-1:0] DUTY_RST = 17'd32768;
  localparam logic [PEAK_W-1:0] PEAK_RST = 16'd9000;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ATTACK = 3'd0,
    REG_DECAY = 3'd1,
    REG_RELEASE = 3'd2,
    REG_SUSTAIN = 3'd3,
    REG_DUTY = 3'd4,
    REG_PEAK = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic kind;
    logic [STEP_BITS-1:0] start_step;
    logic [STEP_BITS-1:0] end_step;
    logic [CFG_LEN_W-1:0] note_samples;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FORM,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ENV_ATTACK,
    ENV_DECAY,
    ENV_RELEASE,
    ENV_SUSTAIN,
    ENV_ZERO
  } env_mode_t;

  typedef struct packed {
    logic load_note;
    logic prep;
    logic form;
    logic mul;
    logic div_start;
    logic apply;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic playing;
    logic div_busy;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/ssav_div.sv @@
`default_nettype none

module ssav_div import ssav_pkg::*; #(
  parameter int QUO_BITS = STEP_BITS,
  parameter int DEN_BITS = LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [QUO_BITS+DEN_BITS-1:0] num,
  input  logic [DEN_BITS-1:0]          den,
  output logic                         busy,
  output logic [QUO_BITS-1:0]          quo
);

  localparam int CNT_W = $clog2(QUO_BITS + 1);

  logic [CNT_W-1:0] count;
  logic [DEN_BITS-1:0] rem;
  logic [QUO_BITS-1:0] quo_r;
  logic [DEN_BITS:0] trial;
  logic [DEN_BITS:0] trial_diff;
  logic qbit;
  logic [DEN_BITS-1:0] rem_next;

  // The quotient is known to fit, so the top part of the numerator starts as the remainder.
  always_comb begin
    trial = {rem, quo_r[QUO_BITS-1]};
    trial_diff = trial - {1'b0, den};
    qbit = (trial >= {1'b0, den});
    rem_next = qbit ? trial_diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(QUO_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[QUO_BITS+DEN_BITS-1:QUO_BITS];
      quo_r <= num[QUO_BITS-1:0];
    end else if (busy) begin
      rem <= rem_next;
      quo_r <= {quo_r[QUO_BITS-2:0], qbit};
    end
  end

  assign busy = (count != '0);
  assign quo = quo_r;

endmodule

`default_nettype wire

@@ src/ssav_dpath.sv @@
`default_nettype none

module ssav_dpath import ssav_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  item_t                  item,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             sts,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int CW = (LENGTH_BITS > CFG_LEN_W) ? LENGTH_BITS + 1 : CFG_LEN_W + 1;
  localparam int SNW = STEP_BITS + LENGTH_BITS;
  localparam int ENW = ENV_W + CFG_LEN_W;
  localparam int MW = ENV_W + PEAK_W;
  localparam int TW = PHASE_BITS + 1;
  localparam int DUTY_SHIFT = PHASE_BITS - 16;

  logic [CFG_LEN_W-1:0] attack_len;
  logic [CFG_LEN_W-1:0] decay_len;
  logic [CFG_LEN_W-1:0] release_len;
  logic [ENV_W-1:0] sustain;
  logic [DUTY_W-1:0] duty;
  logic [PEAK_W-1:0] peak;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [LENGTH_BITS-1:0] sample_index;
  logic [LENGTH_BITS-1:0] note_length;
  logic [STEP_BITS-1:0] sweep_start;
  logic [STEP_BITS-1:0] sweep_end;
  logic playing;

  logic lt_attack;
  logic [CW-1:0] past_attack;
  logic [CW-1:0] release_start;
  logic sweep_up;
  logic [STEP_BITS-1:0] sweep_diff;
  logic [ENV_W-1:0] sustain_sat;

  env_mode_t env_mode;
  env_mode_t env_mode_next;
  logic [ENV_W-1:0] env_fa;
  logic [ENV_W-1:0] env_fa_next;
  logic [CFG_LEN_W-1:0] env_fb;
  logic [CFG_LEN_W-1:0] env_fb_next;
  logic [CFG_LEN_W-1:0] env_den;
  logic [CFG_LEN_W-1:0] env_den_next;

  logic [ENW-1:0] env_num;
  logic [SNW-1:0] sweep_num;
  logic [ENV_W-1:0] env_quo;
  logic [STEP_BITS-1:0] sweep_quo;
  logic env_busy;
  logic sweep_busy;

  logic wave_high;
  logic [MW-1:0] mag_prod;

  logic [CW-1:0] idx_w;
  logic [CW-1:0] attack_w;
  logic [CW-1:0] decay_w;
  logic [CW-1:0] release_w;
  logic [CW-1:0] note_w;
  logic [CW-1:0] into;
  logic [LENGTH_BITS-1:0] note_in;
  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS+PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS-1:0] phase_next;
  logic [TW-1:0] duty_thr;
  logic [ENV_W-1:0] env_val;
  logic [MW-16:0] mag;
  logic [SAMPLE_W-1:0] mag_sat;
  logic [SAMPLE_W-1:0] sample_val;
  logic [LENGTH_BITS:0] idx_inc;
  logic is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len <= '0;
      decay_len <= '0;
      release_len <= '0;
      sustain <= SUSTAIN_RST;
      duty <= DUTY_RST;
      peak <= PEAK_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ATTACK: attack_len <= cfg_data;
        REG_DECAY: decay_len <= cfg_data;
        REG_RELEASE: release_len <= cfg_data;
        REG_SUSTAIN: sustain <= cfg_data[ENV_W-1:0];
        REG_DUTY: duty <= cfg_data[DUTY_W-1:0];
        REG_PEAK: peak <= cfg_data[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    note_in = LENGTH_BITS'(item.note_samples);
    idx_w = CW'(sample_index);
    attack_w = CW'(attack_len);
    decay_w = CW'(decay_len);
    release_w = CW'(release_len);
    note_w = CW'(note_length);
    into = idx_w - release_start;

    step = sweep_up ? sweep_start + sweep_quo : sweep_start - sweep_quo;
    step_ext = {step, {PHASE_BITS{1'b0}}};
    phase_next = phase_acc + step_ext[STEP_BITS +: PHASE_BITS];
    duty_thr = TW'(duty) << DUTY_SHIFT;

    case (env_mode)
      ENV_ATTACK: env_val = env_quo;
      ENV_DECAY: env_val = ENV_ONE - env_quo;
      ENV_RELEASE: env_val = env_quo;
      ENV_SUSTAIN: env_val = sustain_sat;
      default: env_val = '0;
    endcase

    mag = mag_prod[MW-1:15];
    mag_sat = (mag > (MW-15)'(SAT_LIMIT)) ? SAT_LIMIT : mag[SAMPLE_W-1:0];
    sample_val = wave_high ? mag_sat : -mag_sat;
    idx_inc = (LENGTH_BITS+1)'(sample_index) + 1'b1;
    is_last = (idx_inc >= {1'b0, note_length});
  end

  // Envelope segment choice: attack, then decay, then sustain, then the release ramp at the note's end, then zero.
  always_comb begin
    env_mode_next = ENV_SUSTAIN;
    env_fa_next = sustain_sat;
    env_fb_next = '0;
    env_den_next = CFG_LEN_W'(1);
    if (lt_attack) begin
      env_mode_next = ENV_ATTACK;
      env_fa_next = ENV_ONE;
      env_fb_next = idx_w[CFG_LEN_W-1:0];
      env_den_next = attack_len;
    end else if (past_attack < decay_w) begin
      env_mode_next = ENV_DECAY;
      env_fa_next = ENV_ONE - sustain_sat;
      env_fb_next = past_attack[CFG_LEN_W-1:0];
      env_den_next = decay_len;
    end else if ((release_len != '0) && (idx_w >= release_start)) begin
      if (into >= release_w) begin
        env_mode_next = ENV_ZERO;
      end else begin
        env_mode_next = ENV_RELEASE;
        env_fb_next = release_len - into[CFG_LEN_W-1:0];
        env_den_next = release_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_note) begin
      sweep_start <= item.start_step;
      sweep_end <= item.end_step;
      note_length <= (note_in == '0) ? LENGTH_BITS'(1) : note_in;
      sample_index <= '0;
      phase_acc <= '0;
    end else begin
      if (cmd.apply) begin
        phase_acc <= phase_next;
      end
      if (cmd.emit) begin
        sample_index <= idx_inc[LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b0;
    end else if (cmd.load_note) begin
      playing <= 1'b1;
    end else if (cmd.emit && is_last) begin
      playing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      lt_attack <= (idx_w < attack_w);
      past_attack <= idx_w - attack_w;
      release_start <= (note_w > release_w) ? note_w - release_w : '0;
      sweep_up <= (sweep_end >= sweep_start);
      sweep_diff <= (sweep_end >= sweep_start) ? sweep_end - sweep_start
                                               : sweep_start - sweep_end;
      sustain_sat <= (sustain > ENV_ONE) ? ENV_ONE : sustain;
    end
    if (cmd.form) begin
      env_mode <= env_mode_next;
      env_fa <= env_fa_next;
      env_fb <= env_fb_next;
      env_den <= env_den_next;
    end
    if (cmd.mul) begin
      env_num <= ENW'(env_fa) * ENW'(env_fb);
      sweep_num <= SNW'(sweep_diff) * SNW'(sample_index);
    end
    if (cmd.apply) begin
      wave_high <= ({1'b0, phase_next} < duty_thr);
      mag_prod <= MW'(env_val) * MW'(peak);
    end
    if (cmd.emit) begin
      result.sample <= sample_val;
      result.last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  ssav_div #(
    .QUO_BITS(ENV_W),
    .DEN_BITS(CFG_LEN_W)
  ) env_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .num(env_num),
    .den(env_den),
    .busy(env_busy),
    .quo(env_quo)
  );

  ssav_div #(
    .QUO_BITS(STEP_BITS),
    .DEN_BITS(LENGTH_BITS)
  ) sweep_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .num(sweep_num),
    .den(note_length),
    .busy(sweep_busy),
    .quo(sweep_quo)
  );

  assign sts.playing = playing;
  assign sts.div_busy = env_busy | sweep_busy;
  assign sts.slot_free = !result_valid || !result_stall;

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.sample <= 16'sd32000) && (result.sample >= -16'sd32000)))
    else $error("Sample outside the saturation range.");

  assert property (@(posedge clk) disable iff (rst)
    $fell(playing) |-> ($past(cmd.emit) && result_valid && result.last))
    else $error("Note ended without its final sample.");

endmodule

`default_nettype wire

@@ src/ssav_ctrl.sv @@
`default_nettype none

module ssav_ctrl import ssav_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_kind,
  output logic       item_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item_kind == KIND_START) begin
            cmd.load_note = 1'b1;
          end else if (sts.playing) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_FORM;
      end
      ST_FORM: begin
        cmd.form = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> sts.div_busy)
    else $error("Dividers did not start.");

  assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> (state == ST_DIV))
    else $error("Dividers busy outside the divide state.");

endmodule

`default_nettype wire

@@ src/square_sweep_adsr_voice_core.sv @@
// A tick item that finds a note playing runs through the prep, form, mul, load, div, apply and emit states,
// waiting in div for the 24-step sweep divider and in emit for a free output slot; no new item is taken meanwhile.
// Start items and ticks while idle are taken without leaving the idle state and give no sample.
// A finished sample waits in the output register while the next item is accepted.
// Reset is synchronous: the block goes idle and the settings, note flag and output valid take their reset values.
`default_nettype none

module square_sweep_adsr_voice_core import ssav_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  ctrl_cmd_t cmd;
  dp_status_t sts;

  ssav_ctrl ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_kind(item.kind),
    .item_stall(item_stall),
    .sts(sts),
    .cmd(cmd)
  );

  ssav_dpath #(
    .PHASE_BITS(PHASE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dpath (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item),
    .cmd(cmd),
    .sts(sts),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;
  import ssav_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_WAIT = 18;

  typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t op;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    item_t stim;
    bit typed;
    result_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  item_t item_bus;
  logic result_valid;
  logic result_stall;
  result_t result_bus;

  // Copy of the voice: settings and note state.
  logic [CFG_LEN_W-1:0] atk_len, dec_len, rel_len;
  logic [ENV_W-1:0] sus_lvl;
  logic [DUTY_W-1:0] duty_lvl;
  logic [PEAK_W-1:0] peak_lvl;
  logic [STEP_BITS-1:0] phase, sweep_from, sweep_to;
  logic [CFG_LEN_W-1:0] note_pos, note_len;
  bit playing;

  result_t pending_samples[$];
  result_t oldest;
  row_t plan[$];
  bit calm;
  int mismatches;
  int checked;
  int counted_items;
  int notes;
  int settings;

  square_sweep_adsr_voice_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_bus),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint unsigned envelope(input longint unsigned i,
                                               input longint unsigned n);
    longint unsigned a, d, r, s, rs;
    a = atk_len;
    d = dec_len;
    r = rel_len;
    s = (sus_lvl > ENV_ONE) ? ENV_ONE : sus_lvl;
    if (i < a) return (i * ENV_ONE) / a;
    if (i - a < d) return ENV_ONE - ((ENV_ONE - s) * (i - a)) / d;
    if (r > 0) begin
      rs = (n > r) ? n - r : 0;
      if (i >= rs) begin
        if (i - rs >= r) return 0;
        return (s * (r - (i - rs))) / r;
      end
    end
    return s;
  endfunction

  task automatic voice_reset();
    atk_len = '0;
    dec_len = '0;
    rel_len = '0;
    sus_lvl = SUSTAIN_RST;
    duty_lvl = DUTY_RST;
    peak_lvl = PEAK_RST;
    phase = '0;
    sweep_from = '0;
    sweep_to = '0;
    note_pos = '0;
    note_len = '0;
    playing = 1'b0;
  endtask

  task automatic voice_step(input item_t it, output bit made, output result_t r);
    longint unsigned i, n, stp, thr, env, mag;
    logic [SAMPLE_W-1:0] magv;
    bit high;
    made = 1'b0;
    r = '0;
    if (it.kind == KIND_START) begin
      sweep_from = it.start_step;
      sweep_to = it.end_step;
      note_len = (it.note_samples == '0) ? 1 : it.note_samples;
      note_pos = '0;
      phase = '0;
      playing = 1'b1;
      notes++;
    end else if (playing) begin
      i = note_pos;
      n = note_len;
      if (sweep_to >= sweep_from) stp = sweep_from + ((sweep_to - sweep_from) * i) / n;
      else stp = sweep_from - ((sweep_from - sweep_to) * i) / n;
      phase = phase + stp[STEP_BITS-1:0];
      thr = longint'(duty_lvl) << 8;
      high = phase < thr;
      env = envelope(i, n);
      mag = (env * peak_lvl) >> 15;
      if (mag > SAT_LIMIT) mag = SAT_LIMIT;
      magv = mag[SAMPLE_W-1:0];
      r.sample = high ? magv : (16'd0 - magv);
      r.last = (i + 1 >= n);
      note_pos = note_pos + 1'b1;
      if (i + 1 >= n) playing = 1'b0;
      made = 1'b1;
    end
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ATTACK: atk_len = data[CFG_LEN_W-1:0];
      REG_DECAY: dec_len = data[CFG_LEN_W-1:0];
      REG_RELEASE: rel_len = data[CFG_LEN_W-1:0];
      REG_SUSTAIN: sus_lvl = data[ENV_W-1:0];
      REG_DUTY: duty_lvl = data[DUTY_W-1:0];
      REG_PEAK: peak_lvl = data[PEAK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int gap;
    bit made;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (item_stall);
    voice_step(it, made, r);
    if (made) pending_samples.push_back(typed ? want : r);
    if (made || it.kind == KIND_START) counted_items++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic item_t noise_item(input logic kind);
    item_t it;
    it.kind = kind;
    it.start_step = 24'($urandom);
    it.end_step = 24'($urandom);
    it.note_samples = 20'($urandom);
    return it;
  endfunction

  function automatic row_t plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    row_t w;
    w = '0;
    w.op = ROW_WRITE;
    w.reg_index = idx;
    w.reg_value = data;
    return w;
  endfunction

  function automatic row_t plan_note(input logic [STEP_BITS-1:0] s,
                                     input logic [STEP_BITS-1:0] e,
                                     input logic [CFG_LEN_W-1:0] n);
    row_t w;
    w = '0;
    w.op = ROW_ITEM;
    w.stim.kind = KIND_START;
    w.stim.start_step = s;
    w.stim.end_step = e;
    w.stim.note_samples = n;
    return w;
  endfunction

  function automatic row_t plan_tick();
    row_t w;
    w = '0;
    w.op = ROW_ITEM;
    w.stim = '1;
    w.stim.kind = KIND_TICK;
    return w;
  endfunction

  function automatic row_t plan_tick_is(input int s, input bit l);
    row_t w;
    w = plan_tick();
    w.typed = 1'b1;
    w.want.sample = 16'(s);
    w.want.last = l;
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_len(input int style);
    if (style == 0) return '0;
    if (style == 1) return 20'hFFFFF;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 20'hFFFFF;
      2, 3: return 20'($urandom);
      default: return 20'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] roughen(input logic [CFG_DATA_W-1:0] v);
    return ($urandom_range(0, 9) == 0) ? 20'($urandom) : v;
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 4095));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic load_settings(input int style);
    logic [CFG_DATA_W-1:0] sus, duty, peak;
    if (style == 0) begin
      sus = '0;
      duty = '0;
      peak = '0;
    end else if (style == 1) begin
      sus = 20'd65535;
      duty = 20'd65536;
      peak = 20'd65535;
    end else begin
      case ($urandom_range(0, 4))
        0: sus = '0;
        1: sus = 20'd32768;
        2: sus = 20'($urandom_range(0, 65535));
        default: sus = 20'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 4))
        0: duty = '0;
        1: duty = 20'd65536;
        2: duty = 20'($urandom_range(0, 131071));
        default: duty = 20'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 4))
        0: peak = '0;
        1: peak = 20'd65535;
        2: peak = 20'(PEAK_RST);
        default: peak = 20'($urandom_range(0, 65535));
      endcase
    end
    cfg_write(REG_ATTACK, style > 1 ? roughen(pick_len(style)) : pick_len(style));
    cfg_write(REG_DECAY, style > 1 ? roughen(pick_len(style)) : pick_len(style));
    cfg_write(REG_RELEASE, style > 1 ? roughen(pick_len(style)) : pick_len(style));
    cfg_write(REG_SUSTAIN, style > 1 ? roughen(sus) : sus);
    cfg_write(REG_DUTY, style > 1 ? roughen(duty) : duty);
    cfg_write(REG_PEAK, style > 1 ? roughen(peak) : peak);
    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 20'($urandom));
    settings++;
  endtask

  task automatic play_note();
    item_t it;
    int eff, plays;
    if ($urandom_range(0, 9) == 0) send_item(noise_item(1'($urandom)), 1'b0, '0);
    it = noise_item(KIND_START);
    it.start_step = pick_step();
    it.end_step = pick_step();
    case ($urandom_range(0, 19))
      0: it.note_samples = '0;
      1, 2: it.note_samples = 20'($urandom);
      3: it.note_samples = 20'hFFFFF;
      default: it.note_samples = 20'($urandom_range(1, 40));
    endcase
    eff = (it.note_samples == '0) ? 1 : it.note_samples;
    if (eff > 40) plays = $urandom_range(1, 40);
    else if ($urandom_range(0, 9) == 0) plays = $urandom_range(0, eff);
    else plays = eff;
    send_item(it, 1'b0, '0);
    repeat (plays) send_item(noise_item(KIND_TICK), 1'b0, '0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(noise_item(KIND_TICK), 1'b0, '0);
  endtask

  // Receiver: holds stall for a drawn number of cycles with a sample waiting.
  initial begin
    int k;
    result_stall = 1'b0;
    forever begin
      k = calm ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      result_stall <= (k != 0);
      while (k != 0) begin
        @(posedge clk);
        if (result_valid) k--;
        @(negedge clk);
        result_stall <= (k != 0);
      end
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: sample expected none actual %0d last %0b", $time,
                 result_bus.sample, result_bus.last);
        mismatches++;
      end else begin
        oldest = pending_samples.pop_front();
        checked++;
        if (result_bus.sample !== oldest.sample) begin
          $display("%0t: sample expected %0d actual %0d", $time,
                   oldest.sample, result_bus.sample);
          mismatches++;
        end
        if (result_bus.last !== oldest.last) begin
          $display("%0t: last expected %0b actual %0b", $time,
                   oldest.last, result_bus.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit dirty;
    int goal, round;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    item_bus = '0;
    calm = 1'b0;
    mismatches = 0;
    checked = 0;
    counted_items = 0;
    notes = 0;
    settings = 0;
    dirty = 1'b0;
    voice_reset();

    plan.push_back(plan_note(24'h0, 24'h0, 20'd1));
    plan.push_back(plan_tick_is(9000, 1'b1));
    plan.push_back(plan_tick());
    plan.push_back(plan_write(REG_SPARE_LO, 20'hFFFFF));
    plan.push_back(plan_write(REG_SPARE_HI, 20'hFFFFF));
    plan.push_back(plan_note(24'h0, 24'h0, 20'd0));
    plan.push_back(plan_tick_is(9000, 1'b1));
    plan.push_back(plan_write(REG_PEAK, 20'd65535));
    plan.push_back(plan_note(24'h800000, 24'h800000, 20'd1));
    plan.push_back(plan_tick_is(-32000, 1'b1));
    plan.push_back(plan_write(REG_DUTY, 20'd65536));
    plan.push_back(plan_note(24'hFFFFFF, 24'hFFFFFF, 20'd1));
    plan.push_back(plan_tick_is(32000, 1'b1));
    plan.push_back(plan_write(REG_DUTY, 20'd0));
    plan.push_back(plan_write(REG_PEAK, 20'd0));
    plan.push_back(plan_note(24'h0, 24'h0, 20'd2));
    plan.push_back(plan_tick_is(0, 1'b0));
    plan.push_back(plan_tick_is(0, 1'b1));
    plan.push_back(plan_write(REG_PEAK, 20'd9000));
    plan.push_back(plan_write(REG_DUTY, 20'd32768));
    plan.push_back(plan_write(REG_SUSTAIN, 20'd65535));
    plan.push_back(plan_note(24'h0, 24'h0, 20'd1));
    plan.push_back(plan_tick_is(9000, 1'b1));
    plan.push_back(plan_write(REG_SUSTAIN, 20'd16384));
    plan.push_back(plan_note(24'h0, 24'hFFFFFF, 20'd3));
    plan.push_back(plan_tick_is(4500, 1'b0));
    plan.push_back(plan_tick());
    plan.push_back(plan_tick());
    plan.push_back(plan_write(REG_ATTACK, 20'd2));
    plan.push_back(plan_write(REG_DECAY, 20'd2));
    plan.push_back(plan_write(REG_RELEASE, 20'd2));
    plan.push_back(plan_note(24'hFFFFFF, 24'h0, 20'd6));
    repeat (6) plan.push_back(plan_tick());

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].op == ROW_WRITE) begin
        if (dirty) settle();
        dirty = 1'b0;
        cfg_write(plan[k].reg_index, plan[k].reg_value);
      end else begin
        send_item(plan[k].stim, plan[k].typed, plan[k].want);
        dirty = 1'b1;
      end
    end

    goal = counted_items + RANDOM_ITEMS;
    round = 0;
    while (counted_items < goal) begin
      settle();
      load_settings(round);
      calm = (round % 4 == 3);
      repeat ($urandom_range(4, 8)) play_note();
      round++;
    end
    calm = 1'b0;
    settle();

    $display("Played %0d notes and checked %0d samples over %0d register settings,",
             notes, checked, settings);
    $display("with idle ticks, cut-short notes and stalls on both channels.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/ssav_pkg.sv
src/ssav_div.sv
src/ssav_dpath.sv
src/ssav_ctrl.sv
src/square_sweep_adsr_voice_core.sv
test/testbench.sv
